/* rtl/fepd_pkg.sv */
`timescale 1ns / 1ps
// Package for the frame event priority dispatcher.
// Request kind codes, result status codes and the pending frame count width; no dependencies.
package fepd_pkg;

  // Request kinds (codes five to seven are undefined)
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_ADD      = 3'd0;
  localparam kind_t KIND_START    = 3'd1;
  localparam kind_t KIND_TICK     = 3'd2;
  localparam kind_t KIND_DISPATCH = 3'd3;
  localparam kind_t KIND_STOP     = 3'd4;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NOTHING = 3'd1;
  localparam status_t ST_INVALID = 3'd2;
  localparam status_t ST_BUSY    = 3'd3;
  localparam status_t ST_FULL    = 3'd4;
  localparam status_t ST_ALREADY = 3'd5;

  // Width of the pending frame count
  localparam int FRAME_W = 32;

endpackage

/* rtl/fepd_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fepd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read data that holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/frame_event_priority_dispatcher.sv */
`timescale 1ns / 1ps
// Frame event priority dispatcher: sorted handler table in one RAM plus control.
// Depends on fepd_pkg and fepd_ram.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   kind, priority_req, handler_id
//   out_     output     out_valid/out_ready status, entry_handler, frames, wake, last
//
// One request at a time. Start, tick, stop and failed requests pass through the
// execute and response states before their result is registered. An add does one
// RAM read-compare-write per shifted entry, then writes the new entry. A dispatch
// reads, then presents each emitted entry in turn through the single RAM read port.
// Reset clears the flags, the entry count and the pending count; table contents
// stay as they were and only written entries are ever read. A stalled output
// holds the current result; a new request is taken whenever the controller idles.
module frame_event_priority_dispatcher #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_priority_req,
  input  logic [7:0]  in_handler_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_entry_handler,
  output logic [31:0] out_frames,
  output logic        out_wake,
  output logic        out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = fepd_pkg::FRAME_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RESP, S_ADD_CMP, S_ADD_WR, S_DISP_WAIT, S_DISP_EMIT
  } state_t;

  // Registers
  state_t            state_r, state_nxt;
  fepd_pkg::kind_t   kind_r, kind_nxt;
  logic [7:0]        prio_r, prio_nxt;
  logic [7:0]        hid_r, hid_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              sealed_r, sealed_nxt;
  logic              running_r, running_nxt;
  logic [FW-1:0]     pending_r, pending_nxt;
  logic [FW-1:0]     frames_r, frames_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  fepd_pkg::status_t resp_status_r, resp_status_nxt;
  logic              resp_wake_r, resp_wake_nxt;
  logic              out_valid_r, out_valid_nxt;
  fepd_pkg::status_t out_status_r, out_status_nxt;
  logic [7:0]        out_handler_r, out_handler_nxt;
  logic [FW-1:0]     out_frames_r, out_frames_nxt;
  logic              out_wake_r, out_wake_nxt;
  logic              out_last_r, out_last_nxt;

  // RAM port signals: entry = {priority, handler}
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic out_free;
  logic disp_last;

  fepd_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign disp_last = (pos_r + CW'(1)) == count_r;
  assign in_ready  = (state_r == S_IDLE);

  // Control: sequencing, flag updates and RAM access
  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    prio_nxt        = prio_r;
    hid_nxt         = hid_r;
    count_nxt       = count_r;
    sealed_nxt      = sealed_r;
    running_nxt     = running_r;
    pending_nxt     = pending_r;
    frames_nxt      = frames_r;
    pos_nxt         = pos_r;
    resp_status_nxt = resp_status_r;
    resp_wake_nxt   = resp_wake_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_handler_nxt = out_handler_r;
    out_frames_nxt  = out_frames_r;
    out_wake_nxt    = out_wake_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r[AW-1:0];
    ram_wdata       = {prio_r, hid_r};
    ram_re          = 1'b0;
    ram_raddr       = pos_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          prio_nxt  = in_priority_req;
          hid_nxt   = in_handler_id;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        resp_wake_nxt   = 1'b0;
        resp_status_nxt = fepd_pkg::ST_OK;
        state_nxt       = S_RESP;
        case (kind_r)
          fepd_pkg::KIND_ADD: begin
            if (sealed_r) begin
              resp_status_nxt = fepd_pkg::ST_BUSY;
            end else if (count_r >= CAP_C) begin
              resp_status_nxt = fepd_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt   = count_r;
              if (count_r == '0) begin
                state_nxt = S_ADD_WR;
              end else begin
                // fetch the neighbor just below the insertion point
                ram_re    = 1'b1;
                ram_raddr = AW'(count_r - CW'(1));
                state_nxt = S_ADD_CMP;
              end
            end
          end
          fepd_pkg::KIND_START: begin
            if (count_r == '0) begin
              resp_status_nxt = fepd_pkg::ST_INVALID;
            end else if (sealed_r) begin
              resp_status_nxt = fepd_pkg::ST_ALREADY;
            end else begin
              sealed_nxt  = 1'b1;
              running_nxt = 1'b1;
            end
          end
          fepd_pkg::KIND_TICK: begin
            if (running_r) begin
              resp_wake_nxt = (pending_r == '0);
              if (pending_r != '1) begin
                pending_nxt = pending_r + FW'(1);
              end
            end
          end
          fepd_pkg::KIND_DISPATCH: begin
            if (!running_r || pending_r == '0 || count_r == '0) begin
              resp_status_nxt = fepd_pkg::ST_NOTHING;
            end else begin
              frames_nxt  = pending_r;
              pending_nxt = '0;
              pos_nxt     = '0;
              ram_re      = 1'b1;
              ram_raddr   = '0;
              state_nxt   = S_DISP_WAIT;
            end
          end
          fepd_pkg::KIND_STOP: begin
            if (running_r) begin
              running_nxt = 1'b0;
              pending_nxt = '0;
            end
          end
          default: begin
            resp_status_nxt = fepd_pkg::ST_INVALID;
          end
        endcase
      end

      // Single-result completion
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = resp_status_r;
          out_handler_nxt = '0;
          out_frames_nxt  = '0;
          out_wake_nxt    = resp_wake_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      // Shift step: move an entry of equal or higher priority up one slot.
      // The write at pos and the read at pos-2 never hit the same entry.
      S_ADD_CMP: begin
        if (ram_rdata[15:8] >= prio_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - CW'(1);
          if (pos_r == CW'(1)) begin
            state_nxt = S_ADD_WR;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(pos_r - CW'(2));
          end
        end else begin
          ram_we          = 1'b1;
          resp_status_nxt = fepd_pkg::ST_OK;
          resp_wake_nxt   = 1'b0;
          state_nxt       = S_RESP;
        end
      end

      // Drop the new entry into its slot
      S_ADD_WR: begin
        ram_we          = 1'b1;
        resp_status_nxt = fepd_pkg::ST_OK;
        resp_wake_nxt   = 1'b0;
        state_nxt       = S_RESP;
      end

      S_DISP_WAIT: begin
        state_nxt = S_DISP_EMIT;
      end

      // Present one table entry, then fetch the next
      S_DISP_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = fepd_pkg::ST_OK;
          out_handler_nxt = ram_rdata[7:0];
          out_frames_nxt  = frames_r;
          out_wake_nxt    = 1'b0;
          out_last_nxt    = disp_last;
          if (disp_last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + CW'(1);
            ram_re    = 1'b1;
            ram_raddr = AW'(pos_r + CW'(1));
            state_nxt = S_DISP_WAIT;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sealed_r    <= 1'b0;
      running_r   <= 1'b0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sealed_r    <= sealed_nxt;
      running_r   <= running_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r        <= kind_nxt;
    prio_r        <= prio_nxt;
    hid_r         <= hid_nxt;
    frames_r      <= frames_nxt;
    pos_r         <= pos_nxt;
    resp_status_r <= resp_status_nxt;
    resp_wake_r   <= resp_wake_nxt;
    out_status_r  <= out_status_nxt;
    out_handler_r <= out_handler_nxt;
    out_frames_r  <= out_frames_nxt;
    out_wake_r    <= out_wake_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_handler = out_handler_r;
  assign out_frames        = out_frames_r;
  assign out_wake          = out_wake_r;
  assign out_last          = out_last_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C) else $error("entry count above capacity");

  a_running_sealed: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> sealed_r) else $error("running without a sealed table");

  a_pending_running: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != '0) |-> running_r) else $error("frames pending while stopped");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC)) else $error("request not executed");

  a_mid_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == fepd_pkg::ST_OK))
    else $error("non-final result without ok status");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the frame event priority dispatcher.
// Depends on fepd_pkg and the dispatcher RTL; predicts each request's results in-bench.
module tb_top;

  localparam int CAPACITY = 16;

  typedef struct {
    fepd_pkg::kind_t kind;
    logic [7:0]      prio;
    logic [7:0]      hid;
    bit              drain;  // hold this request until every due result is back
  } request_t;

  typedef struct {
    fepd_pkg::status_t status;
    logic [7:0]        handler;
    logic [31:0]       frames;
    logic              wake;
    logic              last;
  } result_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_priority_req = '0;
  logic [7:0]  in_handler_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_entry_handler;
  logic [31:0] out_frames;
  logic        out_wake;
  logic        out_last;

  // Bench state
  request_t pending_requests[$];
  result_t  due_results[$];
  request_t offered;
  int       total_requests = 0;
  int       accepted = 0;
  int       checked = 0;
  int       errors = 0;
  int       wakes_seen = 0;
  int       bursts_seen = 0;
  int       in_gap = 0;
  int       out_hold = 0;
  bit       long_hold_done = 1'b0;

  // Shadow copy of the dispatcher state
  logic [7:0]  tbl_prio [CAPACITY];
  logic [7:0]  tbl_hid [CAPACITY];
  int          n_entries = 0;
  bit          sealed = 1'b0;
  bit          running = 1'b0;
  logic [31:0] pending_frames = '0;

  frame_event_priority_dispatcher #(.CAPACITY(CAPACITY)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_priority_req   (in_priority_req),
    .in_handler_id     (in_handler_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_entry_handler (out_entry_handler),
    .out_frames        (out_frames),
    .out_wake          (out_wake),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  // No idling on either side once the stimulus runs low
  function automatic bit quiet();
    return pending_requests.size() < 40;
  endfunction

  task automatic queue_request(input fepd_pkg::kind_t kind, input logic [7:0] prio,
                               input logic [7:0] hid, input bit drain = 1'b0);
    request_t r;
    r.kind  = kind;
    r.prio  = prio;
    r.hid   = hid;
    r.drain = drain;
    pending_requests.push_back(r);
    total_requests++;
  endtask

  task automatic push_result(input fepd_pkg::status_t st, input logic [7:0] handler,
                             input logic [31:0] frames, input logic wake,
                             input logic last);
    result_t e;
    e.status  = st;
    e.handler = handler;
    e.frames  = frames;
    e.wake    = wake;
    e.last    = last;
    due_results.push_back(e);
  endtask

  // Update the shadow state for one request and queue the results it causes
  task automatic compute_results(input request_t r);
    int                pos;
    fepd_pkg::status_t st;
    logic              wk;
    case (r.kind)
      fepd_pkg::KIND_ADD: begin
        if (sealed) begin
          st = fepd_pkg::ST_BUSY;
        end else if (n_entries >= CAPACITY) begin
          st = fepd_pkg::ST_FULL;
        end else begin
          // new entry goes ahead of equal priorities
          pos = n_entries;
          n_entries++;
          while (pos > 0 && tbl_prio[pos-1] >= r.prio) begin
            tbl_prio[pos] = tbl_prio[pos-1];
            tbl_hid[pos]  = tbl_hid[pos-1];
            pos--;
          end
          tbl_prio[pos] = r.prio;
          tbl_hid[pos]  = r.hid;
          st = fepd_pkg::ST_OK;
        end
        push_result(st, '0, '0, 1'b0, 1'b1);
      end
      fepd_pkg::KIND_START: begin
        if (n_entries == 0) begin
          st = fepd_pkg::ST_INVALID;
        end else if (sealed) begin
          st = fepd_pkg::ST_ALREADY;
        end else begin
          sealed  = 1'b1;
          running = 1'b1;
          st = fepd_pkg::ST_OK;
        end
        push_result(st, '0, '0, 1'b0, 1'b1);
      end
      fepd_pkg::KIND_TICK: begin
        wk = 1'b0;
        if (running) begin
          wk = (pending_frames == '0);
          if (pending_frames != '1) pending_frames++;
        end
        push_result(fepd_pkg::ST_OK, '0, '0, wk, 1'b1);
      end
      fepd_pkg::KIND_DISPATCH: begin
        if (!running || pending_frames == '0 || n_entries == 0) begin
          push_result(fepd_pkg::ST_NOTHING, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < n_entries; i++)
            push_result(fepd_pkg::ST_OK, tbl_hid[i], pending_frames, 1'b0,
                        i == n_entries - 1);
          pending_frames = '0;
        end
      end
      fepd_pkg::KIND_STOP: begin
        if (running) begin
          running = 1'b0;
          pending_frames = '0;
        end
        push_result(fepd_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
      end
      default: push_result(fepd_pkg::ST_INVALID, '0, '0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        compute_results(offered);
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].drain || due_results.size() == 0)) begin
          offered = pending_requests.pop_front();
          in_kind         <= offered.kind;
          in_priority_req <= offered.prio;
          in_handler_id   <= offered.hid;
          in_valid        <= 1'b1;
          if (!quiet() && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report("unrequested result status", 32'(out_status), '0);
        end else begin
          e = due_results.pop_front();
          if (out_status !== e.status)
            report("status", 32'(out_status), 32'(e.status));
          if (out_entry_handler !== e.handler)
            report("entry_handler", 32'(out_entry_handler), 32'(e.handler));
          if (out_frames !== e.frames) report("frames", out_frames, e.frames);
          if (out_wake !== e.wake) report("wake", 32'(out_wake), 32'(e.wake));
          if (out_last !== e.last) report("last", 32'(out_last), 32'(e.last));
          if (e.wake) wakes_seen++;
          if (e.last && e.handler != '0 || e.last && e.frames != '0) bursts_seen++;
        end
        checked++;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && checked >= 300) begin
        // one long back-pressure stretch so the input side stalls
        long_hold_done = 1'b1;
        out_hold = 400;
        out_ready <= 1'b0;
      end else if (!quiet() && $urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int ticks;
    logic [3:0] id_hi;
    // idle-state corner cases
    queue_request(fepd_pkg::KIND_START, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_TICK, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_DISPATCH, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_STOP, 8'h00, 8'h00);
    queue_request(3'd5, 8'hff, 8'hff);
    queue_request(3'd6, 8'h55, 8'haa);
    queue_request(3'd7, 8'haa, 8'h55);
    // fill the table: extreme priorities first, then many ties
    for (int i = 0; i < CAPACITY; i++) begin
      id_hi = (i == 0) ? 4'h0 : (i == CAPACITY - 1) ? 4'hf : 4'($urandom_range(0, 15));
      queue_request(fepd_pkg::KIND_ADD,
                    (i == 0) ? 8'hff : (i == 1) ? 8'h00 :
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 3) * 85),
                    {id_hi, 4'(i)});
    end
    queue_request(fepd_pkg::KIND_ADD, 8'h10, 8'h77);      // table full
    queue_request(fepd_pkg::KIND_START, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_START, 8'h00, 8'h00);    // already started
    queue_request(fepd_pkg::KIND_ADD, 8'h20, 8'h33);      // sealed
    queue_request(fepd_pkg::KIND_TICK, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_DISPATCH, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_DISPATCH, 8'h00, 8'h00); // nothing pending

    // random part: tick bursts closed by a dispatch, with some noise
    while (total_requests < 320) begin
      ticks = $urandom_range(0, 6);
      for (int t = 0; t < ticks; t++)
        queue_request(fepd_pkg::KIND_TICK, 8'($urandom), 8'($urandom),
                      t == 0 && $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: queue_request(fepd_pkg::KIND_ADD, 8'($urandom), 8'($urandom));
          1: queue_request(fepd_pkg::KIND_START, 8'($urandom), 8'($urandom));
          default: queue_request(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom));
        endcase
      end
      queue_request(fepd_pkg::KIND_DISPATCH, 8'($urandom), 8'($urandom));
    end

    // after stop nothing counts any more; the first one waits for a drained output
    queue_request(fepd_pkg::KIND_TICK, 8'h00, 8'h00, 1'b1);
    queue_request(fepd_pkg::KIND_STOP, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_TICK, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_DISPATCH, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_START, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_STOP, 8'h00, 8'h00);
    queue_request(fepd_pkg::KIND_ADD, 8'h01, 8'h02);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_requests || due_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Ran %0d requests through fill, seal, tick/dispatch and stop phases.",
             accepted);
    $display("Checked %0d results: %0d dispatch bursts, %0d wake events.",
             checked, bursts_seen, wakes_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* frame_event_priority_dispatcher.f */
rtl/fepd_pkg.sv
rtl/fepd_ram.sv
rtl/frame_event_priority_dispatcher.sv
bench/tb_top.sv
